// ===== rtl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// Types, codes and keyword tables shared by the JSON byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

    // Token kinds on the result channel
    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_LBRACKET = 4'd2,
        TK_RBRACKET = 4'd3,
        TK_STRING   = 4'd4,
        TK_NUMBER   = 4'd5,
        TK_TRUE     = 4'd6,
        TK_FALSE    = 4'd7,
        TK_NULL     = 4'd8,
        TK_END      = 4'd9,
        TK_ERROR    = 4'd10
    } token_kind_t;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_KEYWORD = 3'd3,
        MODE_DROP    = 3'd4
    } scan_mode_t;

    // Keyword selector
    typedef enum logic [1:0] {
        KW_TRUE  = 2'd0,
        KW_FALSE = 2'd1,
        KW_NULL  = 2'd2
    } kw_sel_t;

    // Character constants
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    localparam int unsigned MAX_RESULTS = 3;

    // One input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        token_kind_t token_kind;
        logic [7:0]  content_byte;
        logic        has_content;
        logic        token_done;
        logic        run_last;
    } token_t;

    // Results produced by one byte, core to buffer
    typedef struct packed {
        logic [1:0]                   cnt;
        token_t [MAX_RESULTS-1:0]     ent;
    } res_set_t;

    // Keyword spelling, indexed by selector and position
    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            KW_TRUE:
                case (i)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            KW_FALSE:
                case (i)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            default:
                case (i)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h00;
                endcase
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] w);
        logic [2:0] n;
        case (w)
            KW_FALSE: n = 3'd5;
            default:  n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic token_t mk_tok(input token_kind_t kind, input logic [7:0] b,
                                      input logic has, input logic done);
        token_t t;
        t.token_kind   = kind;
        t.content_byte = has ? b : 8'h00;
        t.has_content  = has;
        t.token_done   = done;
        t.run_last     = 1'b0;
        return t;
    endfunction

endpackage

// ===== rtl/jbt_stream_if.sv =====
// ----------------------------------------------------------------------------
// jbt_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface jbt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/json_byte_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit
// Streaming JSON lexer: bytes in, token results out.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle while results are taken. A byte's first
// result is offered once it has passed the input register and the result
// buffer; further results follow one per cycle while the output is ready.
// While results are taken, a byte that produces no result or one result
// leaves the input open every cycle; a byte that produces two or three
// results (a number closed by the next token, or a token on the final byte
// followed by the end token) holds the input until its last result is
// taken, since the buffer hands out one result per transaction. Each result
// of a byte carries run_last on the last one; after an error the rest of the
// document up to and including its final byte is consumed without results.
module json_byte_tokenizer_unit
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jbt_stream_if.sink   text_in,
    jbt_stream_if.source token_out
);

    res_set_t res;
    logic     load;
    logic     load_ok;
    in_item_t in_item;
    token_t   out_item;

    assign in_item        = text_in.data;
    assign token_out.data = out_item;

    // Lexing stage
    jbt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .in_data  (in_item),
        .load_ok  (load_ok),
        .load     (load),
        .res      (res)
    );

    // Result buffer
    jbt_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (token_out.valid),
        .out_ready (token_out.ready),
        .out_data  (out_item)
    );

endmodule

// ===== rtl/jbt_core.sv =====
// ----------------------------------------------------------------------------
// jbt_core
// Input register, scanner state and the single-pass lexing logic that turns
// one byte into up to three results.
// ----------------------------------------------------------------------------
module jbt_core
    import jbt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  in_item_t       in_data,
    input  logic           load_ok,
    output logic           load,
    output res_set_t       res
);

    logic       v_reg;
    in_item_t   item_reg;
    scan_mode_t scan_mode_reg, scan_mode_next;
    logic [1:0] kw_which_reg, kw_which_next;
    logic [2:0] kw_index_reg, kw_index_next;

    // Item moves on when the buffer can take its results
    assign load     = v_reg && load_ok;
    assign in_ready = !v_reg || load_ok;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= MODE_IDLE;
            kw_which_reg  <= 2'd0;
            kw_index_reg  <= 3'd0;
        end
        else if (load)
        begin
            scan_mode_reg <= scan_mode_next;
            kw_which_reg  <= kw_which_next;
            kw_index_reg  <= kw_index_next;
        end
    end

    // Lexing logic
    always_comb
    begin
        logic [7:0] b;
        logic       fin;
        logic       sp, dig;
        // idle-byte handling
        logic       i_v, i_ok, i_kw;
        token_t     i_tok;
        scan_mode_t i_mode;
        logic [1:0] i_which;
        // keyword match
        logic [1:0] w;
        logic [2:0] len, idx, idx1;
        token_kind_t kw_kind;
        // result slots
        logic       a_v, b_v, c_v, ok, drop;
        token_t     a_tok, b_tok, c_tok;

        b   = item_reg.text_byte;
        fin = item_reg.final_byte;
        sp  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        dig = (b >= CH_ZERO) && (b <= CH_NINE);

        // byte as seen with no token open
        i_v     = 1'b0;
        i_ok    = 1'b1;
        i_kw    = 1'b0;
        i_tok   = mk_tok(TK_ERROR, 8'h00, 1'b0, 1'b1);
        i_mode  = MODE_IDLE;
        i_which = KW_NULL;
        if (sp || b == CH_COMMA || b == CH_COLON)
        begin
            i_v = 1'b0;
        end
        else if (b == CH_LBRACE)
        begin
            i_v   = 1'b1;
            i_tok = mk_tok(TK_LBRACE, 8'h00, 1'b0, 1'b1);
        end
        else if (b == CH_RBRACE)
        begin
            i_v   = 1'b1;
            i_tok = mk_tok(TK_RBRACE, 8'h00, 1'b0, 1'b1);
        end
        else if (b == CH_LBRACKET)
        begin
            i_v   = 1'b1;
            i_tok = mk_tok(TK_LBRACKET, 8'h00, 1'b0, 1'b1);
        end
        else if (b == CH_RBRACKET)
        begin
            i_v   = 1'b1;
            i_tok = mk_tok(TK_RBRACKET, 8'h00, 1'b0, 1'b1);
        end
        else if (b == CH_QUOTE)
        begin
            i_v    = fin;
            i_tok  = mk_tok(TK_STRING, 8'h00, 1'b0, 1'b1);
            i_mode = fin ? MODE_IDLE : MODE_STRING;
        end
        else if (dig || b == CH_MINUS)
        begin
            i_v    = 1'b1;
            i_tok  = mk_tok(TK_NUMBER, b, 1'b1, fin);
            i_mode = fin ? MODE_IDLE : MODE_NUMBER;
        end
        else if (b == CH_T || b == CH_F || b == CH_N)
        begin
            if (fin)
            begin
                i_v  = 1'b1;
                i_ok = 1'b0;
            end
            else
            begin
                i_kw    = 1'b1;
                i_mode  = MODE_KEYWORD;
                i_which = (b == CH_T) ? KW_TRUE : ((b == CH_F) ? KW_FALSE : KW_NULL);
            end
        end
        else
        begin
            i_v  = 1'b1;
            i_ok = 1'b0;
        end

        // keyword position, clamped into the spelling
        w    = (kw_which_reg > KW_NULL) ? KW_NULL : kw_which_reg;
        len  = kw_len(w);
        idx  = (kw_index_reg >= len) ? (len - 3'd1) : kw_index_reg;
        idx1 = idx + 3'd1;
        case (w)
            KW_TRUE:  kw_kind = TK_TRUE;
            KW_FALSE: kw_kind = TK_FALSE;
            default:  kw_kind = TK_NULL;
        endcase

        a_v   = 1'b0;
        b_v   = 1'b0;
        c_v   = 1'b0;
        a_tok = i_tok;
        b_tok = i_tok;
        c_tok = mk_tok(TK_END, 8'h00, 1'b0, 1'b1);
        ok    = 1'b1;
        drop  = 1'b0;
        scan_mode_next = MODE_IDLE;
        kw_which_next  = kw_which_reg;
        kw_index_next  = kw_index_reg;

        case (scan_mode_reg)
            MODE_DROP:
            begin
                drop           = 1'b1;
                scan_mode_next = fin ? MODE_IDLE : MODE_DROP;
            end
            MODE_STRING:
            begin
                a_v = 1'b1;
                if (b == CH_QUOTE)
                begin
                    a_tok = mk_tok(TK_STRING, 8'h00, 1'b0, 1'b1);
                end
                else
                begin
                    a_tok          = mk_tok(TK_STRING, b, 1'b1, fin);
                    scan_mode_next = fin ? MODE_IDLE : MODE_STRING;
                end
            end
            MODE_NUMBER:
            begin
                a_v = 1'b1;
                if (dig || b == CH_DOT)
                begin
                    a_tok          = mk_tok(TK_NUMBER, b, 1'b1, fin);
                    scan_mode_next = fin ? MODE_IDLE : MODE_NUMBER;
                end
                else
                begin
                    // close the number, then treat the byte afresh
                    a_tok          = mk_tok(TK_NUMBER, 8'h00, 1'b0, 1'b1);
                    b_v            = i_v;
                    b_tok          = i_tok;
                    ok             = i_ok;
                    scan_mode_next = i_mode;
                    if (i_kw)
                    begin
                        kw_which_next = i_which;
                        kw_index_next = 3'd1;
                    end
                end
            end
            MODE_KEYWORD:
            begin
                if (b == kw_char(w, idx))
                begin
                    if (idx1 == len)
                    begin
                        a_v           = 1'b1;
                        a_tok         = mk_tok(kw_kind, 8'h00, 1'b0, 1'b1);
                        kw_index_next = 3'd0;
                    end
                    else if (fin)
                    begin
                        a_v   = 1'b1;
                        a_tok = mk_tok(TK_ERROR, 8'h00, 1'b0, 1'b1);
                        ok    = 1'b0;
                    end
                    else
                    begin
                        kw_index_next  = idx1;
                        scan_mode_next = MODE_KEYWORD;
                    end
                end
                else
                begin
                    a_v   = 1'b1;
                    a_tok = mk_tok(TK_ERROR, 8'h00, 1'b0, 1'b1);
                    ok    = 1'b0;
                end
            end
            default:
            begin
                a_v            = i_v;
                a_tok          = i_tok;
                ok             = i_ok;
                scan_mode_next = i_mode;
                if (i_kw)
                begin
                    kw_which_next = i_which;
                    kw_index_next = 3'd1;
                end
            end
        endcase

        // error drops the document, the final byte closes it
        if (!drop)
        begin
            if (!ok)
            begin
                scan_mode_next = fin ? MODE_IDLE : MODE_DROP;
                kw_index_next  = 3'd0;
            end
            else if (fin)
            begin
                c_v            = 1'b1;
                scan_mode_next = MODE_IDLE;
            end
        end

        // pack slots in order; the second slot is only used after the first
        res.cnt    = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};
        res.ent[0] = a_v ? a_tok : c_tok;
        res.ent[1] = b_v ? b_tok : c_tok;
        res.ent[2] = c_tok;
        res.ent[0].run_last = (res.cnt == 2'd1);
        res.ent[1].run_last = (res.cnt == 2'd2);
        res.ent[2].run_last = (res.cnt == 2'd3);
    end

`ifndef ASSERT_OFF
    // A keyword in progress has matched its first byte and not the whole word
    a_kw_index: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_mode_reg == MODE_KEYWORD) |-> (kw_index_reg >= 3'd1 && kw_index_reg <= 3'd4))
        else $error("keyword index out of range");

    // The final byte always leaves the scanner idle
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && item_reg.final_byte) |=> (scan_mode_reg == MODE_IDLE))
        else $error("scanner not idle after final byte");

    // Bytes dropped after an error produce nothing
    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (load && scan_mode_reg == MODE_DROP) |-> (res.cnt == 2'd0))
        else $error("result while dropping");
`endif

endmodule

// ===== rtl/jbt_result_buf.sv =====
// ----------------------------------------------------------------------------
// jbt_result_buf
// Holds the results of one byte and hands them out one per transaction.
// ----------------------------------------------------------------------------
module jbt_result_buf
    import jbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  res_set_t res,
    output logic     load_ok,
    output logic     out_valid,
    input  logic     out_ready,
    output token_t   out_data
);

    token_t [2:0] ent_reg;
    logic   [1:0] cnt_reg, cnt_next;
    logic   [1:0] rd_reg, rd_next;
    logic         take;

    assign out_valid = (rd_reg < cnt_reg);
    assign take      = out_valid && out_ready;
    // empty, or the last pending result leaves this cycle
    assign load_ok   = (rd_reg == cnt_reg) || (take && (rd_reg + 2'd1 == cnt_reg));

    // Read pointer and fill
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load)
        begin
            cnt_next = res.cnt;
            rd_next  = 2'd0;
        end
        else if (take)
        begin
            rd_next = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= res.ent;
        end
    end

    // Output select
    always_comb
    begin
        case (rd_reg)
            2'd0:    out_data = ent_reg[0];
            2'd1:    out_data = ent_reg[1];
            default: out_data = ent_reg[2];
        endcase
    end

`ifndef ASSERT_OFF
    // Read pointer never passes the fill
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= cnt_reg)
        else $error("read pointer beyond fill");

    // The flag on the last result of a byte matches the pointer
    a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.run_last == ({1'b0, rd_reg} + 3'd1 == {1'b0, cnt_reg})))
        else $error("run_last misplaced");

    // A non-empty load is offered in the next cycle
    a_load_show: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res.cnt != 2'd0) |=> out_valid)
        else $error("loaded results not offered");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming JSON tokenizer. Feeds whole documents
// one byte per transaction, predicts the token stream with an independent
// lexer model and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
    import jbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Whitespace codes not provided by the package
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    logic clk = 1'b0;
    logic rst_n;

    jbt_stream_if #(.payload_t(in_item_t)) text_if ();
    jbt_stream_if #(.payload_t(token_t))   tok_if ();

    json_byte_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (tok_if)
    );

    always #10 clk = ~clk;

    // Lexer model state
    scan_mode_t  lex_mode;
    kw_sel_t     kw_word;
    logic [2:0]  kw_pos;
    string       kw_spell [3] = '{"true", "false", "null"};

    token_t      step_tokens[$];
    token_t      pending_tokens[$];
    logic [7:0]  doc_buf[$];

    // Traffic shaping
    bit          feed_gaps;
    bit          drain_stalls;
    int          sink_hold_cycles;

    // Run statistics
    int          fail_count;
    int          docs_sent;
    int          bytes_live;
    int          bytes_dropped;
    int          tokens_checked;
    int          error_tokens;

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    function void add_token(token_kind_t kind, logic [7:0] b, logic has, logic done);
        token_t t;
        t.token_kind   = kind;
        t.content_byte = has ? b : 8'h00;
        t.has_content  = has;
        t.token_done   = done;
        t.run_last     = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_COMMA || b == CH_COLON;
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Byte seen with nothing open; returns 0 on a lexical error
    function bit lex_fresh(logic [7:0] b, logic fin);
        if (is_blank(b))
            return 1'b1;
        if (b == CH_LBRACE) begin add_token(TK_LBRACE, 8'h00, 1'b0, 1'b1); return 1'b1; end
        if (b == CH_RBRACE) begin add_token(TK_RBRACE, 8'h00, 1'b0, 1'b1); return 1'b1; end
        if (b == CH_LBRACKET) begin add_token(TK_LBRACKET, 8'h00, 1'b0, 1'b1); return 1'b1; end
        if (b == CH_RBRACKET) begin add_token(TK_RBRACKET, 8'h00, 1'b0, 1'b1); return 1'b1; end
        if (b == CH_QUOTE) begin
            if (fin)
                add_token(TK_STRING, 8'h00, 1'b0, 1'b1);
            else
                lex_mode = MODE_STRING;
            return 1'b1;
        end
        if (is_digit(b) || b == CH_MINUS) begin
            add_token(TK_NUMBER, b, 1'b1, fin);
            if (!fin)
                lex_mode = MODE_NUMBER;
            return 1'b1;
        end
        if (b == CH_T || b == CH_F || b == CH_N) begin
            if (fin) begin
                add_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
                return 1'b0;
            end
            kw_word  = (b == CH_T) ? KW_TRUE : ((b == CH_F) ? KW_FALSE : KW_NULL);
            kw_pos   = 3'd1;
            lex_mode = MODE_KEYWORD;
            return 1'b1;
        end
        add_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
        return 1'b0;
    endfunction

    // Advance the model by one accepted byte and queue its tokens
    function void tokenize_byte(logic [7:0] b, logic fin);
        scan_mode_t  prev;
        bit          ok;
        int          word_len;
        token_kind_t kw_kind;
        prev     = lex_mode;
        ok       = 1'b1;
        lex_mode = MODE_IDLE;
        step_tokens.delete();
        case (prev)
            MODE_DROP:
            begin
                if (!fin)
                    lex_mode = MODE_DROP;
                return;
            end
            MODE_STRING:
            begin
                if (b == CH_QUOTE)
                    add_token(TK_STRING, 8'h00, 1'b0, 1'b1);
                else
                begin
                    add_token(TK_STRING, b, 1'b1, fin);
                    if (!fin)
                        lex_mode = MODE_STRING;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(b) || b == CH_DOT)
                begin
                    add_token(TK_NUMBER, b, 1'b1, fin);
                    if (!fin)
                        lex_mode = MODE_NUMBER;
                end
                else
                begin
                    // number closes, then the byte starts afresh
                    add_token(TK_NUMBER, 8'h00, 1'b0, 1'b1);
                    ok = lex_fresh(b, fin);
                end
            end
            MODE_KEYWORD:
            begin
                word_len = (kw_word == KW_FALSE) ? 5 : 4;
                kw_kind  = (kw_word == KW_TRUE) ? TK_TRUE :
                           ((kw_word == KW_FALSE) ? TK_FALSE : TK_NULL);
                if (b == kw_spell[kw_word][kw_pos])
                begin
                    if (kw_pos + 1 == word_len)
                    begin
                        add_token(kw_kind, 8'h00, 1'b0, 1'b1);
                        kw_pos = 3'd0;
                    end
                    else if (fin)
                    begin
                        add_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
                        ok = 1'b0;
                    end
                    else
                    begin
                        kw_pos   = kw_pos + 3'd1;
                        lex_mode = MODE_KEYWORD;
                    end
                end
                else
                begin
                    add_token(TK_ERROR, 8'h00, 1'b0, 1'b1);
                    ok = 1'b0;
                end
            end
            default:
                ok = lex_fresh(b, fin);
        endcase

        if (!ok)
        begin
            lex_mode = fin ? MODE_IDLE : MODE_DROP;
            kw_pos   = 3'd0;
        end
        else if (fin)
        begin
            add_token(TK_END, 8'h00, 1'b0, 1'b1);
            lex_mode = MODE_IDLE;
        end

        if (step_tokens.size() > 0)
            step_tokens[$].run_last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and initial drive
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.data  <= '0;
        lex_mode      = MODE_IDLE;
        kw_word       = KW_TRUE;
        kw_pos        = 3'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random short stalls, or a long hold-off when requested
    initial
    begin : result_sink
        tok_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
                tok_if.ready <= 1'b1;
            end
            else if (drain_stalls && $urandom_range(0, 5) == 0)
            begin
                tok_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                tok_if.ready <= 1'b1;
            end
            else
                tok_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function void check_field(string name, int unsigned want, int unsigned got);
        if (want !== got)
        begin
            $display("%t mismatch on %s: expected %0h actual %0h", $realtime, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        token_t got;
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            got = tok_if.data;
            if (pending_tokens.size() == 0)
            begin
                $display("%t unexpected token: expected none actual %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", want.token_kind, got.token_kind);
                check_field("content_byte", want.content_byte, got.content_byte);
                check_field("has_content", want.has_content, got.has_content);
                check_field("token_done", want.token_done, got.token_done);
                check_field("run_last", want.run_last, got.run_last);
                tokens_checked++;
                if (want.token_kind == TK_ERROR)
                    error_tokens++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // One byte transaction; optional gap afterwards
    task automatic send_byte(input logic [7:0] b, input logic fin);
        text_if.valid <= 1'b1;
        text_if.data  <= '{text_byte: b, final_byte: fin};
        do
            @(posedge clk);
        while (!text_if.ready);
        if (lex_mode == MODE_DROP)
            bytes_dropped++;
        else
            bytes_live++;
        tokenize_byte(b, fin);
        if (feed_gaps && $urandom_range(0, 4) == 0)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_buf.size(); i++)
            send_byte(doc_buf[i], i == doc_buf.size() - 1);
        docs_sent++;
    endtask

    // Sender pauses until every predicted token has come back
    task automatic wait_drained();
        int guard;
        guard = 0;
        text_if.valid <= 1'b0;
        while (pending_tokens.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    function void load_text(string s);
        doc_buf.delete();
        for (int i = 0; i < s.len(); i++)
            doc_buf.push_back(s[i]);
    endfunction

    function logic [7:0] pick_sep();
        case ($urandom_range(0, 7))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            5:       return CH_CR;
            6:       return CH_COMMA;
            default: return CH_COLON;
        endcase
    endfunction

    // Mostly well-formed token sequences with random content, some noise
    function void make_doc();
        int         n_tok;
        int         pick;
        int         len;
        int         cut;
        string      kw;
        logic [7:0] b;
        doc_buf.delete();
        n_tok = $urandom_range(1, 6);
        repeat (n_tok)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                case ($urandom_range(0, 3))
                    0:       doc_buf.push_back(CH_LBRACE);
                    1:       doc_buf.push_back(CH_RBRACE);
                    2:       doc_buf.push_back(CH_LBRACKET);
                    default: doc_buf.push_back(CH_RBRACKET);
                endcase
            end
            else if (pick < 40)
            begin
                // string, occasionally left open
                doc_buf.push_back(CH_QUOTE);
                len = $urandom_range(0, 4);
                repeat (len)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE);
                    doc_buf.push_back(b);
                end
                if ($urandom_range(0, 9) != 0)
                    doc_buf.push_back(CH_QUOTE);
            end
            else if (pick < 62)
            begin
                if ($urandom_range(0, 2) == 0)
                    doc_buf.push_back(CH_MINUS);
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                        doc_buf.push_back(CH_DOT);
                    else
                        doc_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 2))
                    0:       kw = "true";
                    1:       kw = "false";
                    default: kw = "null";
                endcase
                if ($urandom_range(0, 7) == 0)
                begin
                    // keyword broken part way through
                    cut = $urandom_range(1, kw.len() - 1);
                    for (int i = 0; i < cut; i++)
                        doc_buf.push_back(kw[i]);
                    doc_buf.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    for (int i = 0; i < kw.len(); i++)
                        doc_buf.push_back(kw[i]);
                end
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 2))
                    doc_buf.push_back(pick_sep());
            end
            else
                doc_buf.push_back(8'($urandom_range(0, 255)));

            if ($urandom_range(0, 2) == 0)
                doc_buf.push_back(pick_sep());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        feed_gaps    = 1'b1;
        drain_stalls = 1'b1;
        // number closed by a brace on the final byte: three results
        load_text("{\"k\":-1.5}");
        send_doc();
        // open string cut off by the final byte
        load_text("\"ab");
        send_doc();
        // lone opening quote as the final byte
        load_text("\"");
        send_doc();
        // keyword incomplete at the final byte
        load_text("fals");
        send_doc();
        // keyword mismatch on 0xFF, rest dropped
        load_text("nu");
        doc_buf.push_back(8'hFF);
        doc_buf.push_back(CH_RBRACKET);
        send_doc();
        // illegal byte on its own
        doc_buf.delete();
        doc_buf.push_back(8'h00);
        send_doc();
        // whitespace only: just the end token
        load_text(" ");
        send_doc();
        wait_drained();
    endtask

    task automatic test_random_docs(input int n_items, input bit gaps);
        int start;
        start        = bytes_live;
        feed_gaps    = gaps;
        drain_stalls = gaps;
        while (bytes_live - start < n_items)
        begin
            make_doc();
            send_doc();
        end
        wait_drained();
    endtask

    // Result side held off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        int start;
        start            = bytes_live;
        feed_gaps        = 1'b0;
        drain_stalls     = 1'b0;
        sink_hold_cycles = 60;
        while (bytes_live - start < 60)
        begin
            make_doc();
            send_doc();
        end
        wait_drained();
    endtask

    initial
    begin : run_tests
        fail_count       = 0;
        docs_sent        = 0;
        bytes_live       = 0;
        bytes_dropped    = 0;
        tokens_checked   = 0;
        error_tokens     = 0;
        sink_hold_cycles = 0;
        feed_gaps        = 1'b0;
        drain_stalls     = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        test_directed();
        test_random_docs(250, 1'b1);
        test_backpressure();
        test_random_docs(140, 1'b0);

        repeat (10) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $display("%t missing tokens: expected %0d more actual 0", $realtime,
                     pending_tokens.size());
            fail_count++;
        end
        $display("Covered %0d documents, %0d bytes tokenised and %0d dropped after errors,",
                 docs_sent, bytes_live, bytes_dropped);
        $display("%0d tokens checked (%0d errors), with stalls and a long hold-off.",
                 tokens_checked, error_tokens);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
